### sv/nbl_pkg.sv
// ============================================================================
// N-body leapfrog package
// Shared constants, request codes, datapath operation codes, command and
// status structures, and the 32-bit saturation helper.
// ============================================================================
package nbl_pkg;

    // Body store size and index width.
    localparam int NUM_BODIES = 4;
    localparam int IDX_W      = $clog2(NUM_BODIES);
    localparam int FRAC_BITS  = 24;

    // Time step register reset value (Q0.24).
    localparam logic [23:0] STEP_RESET = 24'd5033;

    // Iteration counts of the shared serial units.
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 40;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_STEP = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Datapath operation codes.
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_LOAD      = 5'd1;
    localparam t_op OP_CLR_ERR   = 5'd2;
    localparam t_op OP_DRIFT     = 5'd3;
    localparam t_op OP_LATCH     = 5'd4;
    localparam t_op OP_DIFF      = 5'd5;
    localparam t_op OP_SQX       = 5'd6;
    localparam t_op OP_SQY       = 5'd7;
    localparam t_op OP_COIN      = 5'd8;
    localparam t_op OP_SQRT_INIT = 5'd9;
    localparam t_op OP_SQRT_STEP = 5'd10;
    localparam t_op OP_DEN_LO    = 5'd11;
    localparam t_op OP_DEN_HI    = 5'd12;
    localparam t_op OP_NUM       = 5'd13;
    localparam t_op OP_DIV_INIT  = 5'd14;
    localparam t_op OP_DIV_STEP  = 5'd15;
    localparam t_op OP_ACC       = 5'd16;
    localparam t_op OP_ST_ACC    = 5'd17;
    localparam t_op OP_KICK      = 5'd18;
    localparam t_op OP_EMIT      = 5'd19;

    // Command from controller to datapath.
    typedef struct packed {
        t_op              op;
        logic             axis;   // 0 for x, 1 for y
        logic [IDX_W-1:0] idx;    // body addressed by this operation
        logic             rd;     // emit belongs to a read request
        logic             last;   // emit is the final result of the request
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic r2_zero;            // squared distance of the current pair is zero
        logic err;                // error flag of the current step
    } t_sts;

    // Saturated 32-bit value and overflow indication.
    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } t_sat;

    // Clamp a 42-bit signed value into 32 bits signed.
    function automatic t_sat sat32(input logic signed [41:0] v);
        t_sat r;
        if (v > 42'sh0007FFFFFFF) begin
            r.val = 32'sh7FFFFFFF;
            r.ovf = 1'b1;
        end else if (v < -42'sh00080000000) begin
            r.val = 32'sh80000000;
            r.ovf = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

### sv/nbl_if.sv
// ============================================================================
// N-body leapfrog channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ============================================================================

// Request channel.
interface nbl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  body_index;
    logic [30:0] body_mass;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;

    modport source (output valid, req_type, body_index, body_mass, load_pos_x,
                    load_pos_y, load_vel_x, load_vel_y, input ready);
    modport sink   (input valid, req_type, body_index, body_mass, load_pos_x,
                    load_pos_y, load_vel_x, load_vel_y, output ready);
endinterface

// Result channel.
interface nbl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic        error_flag;
    logic        last_result;

    modport source (output valid, out_index, out_pos_x, out_pos_y, out_vel_x,
                    out_vel_y, error_flag, last_result, input ready);
    modport sink   (input valid, out_index, out_pos_x, out_pos_y, out_vel_x,
                    out_vel_y, error_flag, last_result, output ready);
endinterface

// Configuration write channel for the time step register.
interface nbl_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] step_size;

    modport source (output valid, step_size, input ready);
    modport sink   (input valid, step_size, output ready);
endinterface

### sv/nbl_ctrl.sv
// ============================================================================
// N-body leapfrog controller
// Sequences load, read and step requests into datapath operations.
// ============================================================================
module nbl_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [1:0]               i_req_type,
    input  logic [1:0]               i_body_index,
    output logic                     o_in_ready,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    input  nbl_pkg::t_sts            i_sts,
    output nbl_pkg::t_cmd            o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DRIFT1 = 5'd1;
    localparam logic [4:0] S_LATCH  = 5'd2;
    localparam logic [4:0] S_PAIR   = 5'd3;
    localparam logic [4:0] S_SQX    = 5'd4;
    localparam logic [4:0] S_SQY    = 5'd5;
    localparam logic [4:0] S_CHK    = 5'd6;
    localparam logic [4:0] S_SQRT   = 5'd7;
    localparam logic [4:0] S_DENLO  = 5'd8;
    localparam logic [4:0] S_DENHI  = 5'd9;
    localparam logic [4:0] S_NUM    = 5'd10;
    localparam logic [4:0] S_DIVI   = 5'd11;
    localparam logic [4:0] S_DIV    = 5'd12;
    localparam logic [4:0] S_ACC    = 5'd13;
    localparam logic [4:0] S_STACC  = 5'd14;
    localparam logic [4:0] S_KICK   = 5'd15;
    localparam logic [4:0] S_DRIFT2 = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    localparam int IW = nbl_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(nbl_pkg::NUM_BODIES - 1);
    localparam logic [5:0] SQRT_LAST = 6'(nbl_pkg::SQRT_STEPS - 1);
    localparam logic [5:0] DIV_LAST  = 6'(nbl_pkg::DIV_STEPS - 1);

    logic [4:0]    r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_axis, n_axis;
    logic          r_rd, n_rd;
    logic          r_ov, n_ov;
    logic          slot_free;
    logic          accept;
    logic          i_last, j_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_ov || i_out_ready;
    assign i_last      = (r_i == LAST_IDX);
    assign j_last      = (r_j == LAST_IDX);

    // Next state and command generation.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        n_rd    = r_rd;
        n_ov    = r_ov && !i_out_ready;
        o_cmd      = '0;
        o_cmd.op   = nbl_pkg::OP_NOP;
        o_cmd.axis = r_axis;
        o_cmd.idx  = r_i;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == nbl_pkg::REQ_LOAD) begin
                        o_cmd.op  = nbl_pkg::OP_LOAD;
                        o_cmd.idx = IW'(i_body_index);
                    end else if (i_req_type == nbl_pkg::REQ_STEP) begin
                        o_cmd.op = nbl_pkg::OP_CLR_ERR;
                        n_i      = '0;
                        n_axis   = 1'b0;
                        n_rd     = 1'b0;
                        n_state  = S_DRIFT1;
                    end else if (i_req_type == nbl_pkg::REQ_READ) begin
                        n_j     = IW'(i_body_index);
                        n_rd    = 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_DRIFT1: begin
                o_cmd.op = nbl_pkg::OP_DRIFT;
                n_axis   = !r_axis;
                if (r_axis) begin
                    n_i = r_i + 1'b1;
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_LATCH;
                    end
                end
            end
            S_LATCH: begin
                o_cmd.op = nbl_pkg::OP_LATCH;
                n_j      = '0;
                n_state  = S_PAIR;
            end
            S_PAIR: begin
                if (r_j == r_i) begin
                    n_j     = r_j + 1'b1;
                    n_state = j_last ? S_STACC : S_PAIR;
                end else begin
                    o_cmd.op  = nbl_pkg::OP_DIFF;
                    o_cmd.idx = r_j;
                    n_state   = S_SQX;
                end
            end
            S_SQX: begin
                o_cmd.op = nbl_pkg::OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = nbl_pkg::OP_SQY;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.r2_zero) begin
                    // Coincident pair: flag it and go on to the next partner.
                    o_cmd.op = nbl_pkg::OP_COIN;
                    n_j      = r_j + 1'b1;
                    n_state  = j_last ? S_STACC : S_PAIR;
                end else begin
                    o_cmd.op = nbl_pkg::OP_SQRT_INIT;
                    n_cnt    = '0;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = nbl_pkg::OP_SQRT_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_DENLO;
                end
            end
            S_DENLO: begin
                o_cmd.op = nbl_pkg::OP_DEN_LO;
                n_state  = S_DENHI;
            end
            S_DENHI: begin
                o_cmd.op = nbl_pkg::OP_DEN_HI;
                n_axis   = 1'b0;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = nbl_pkg::OP_NUM;
                n_state  = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.op = nbl_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = nbl_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = nbl_pkg::OP_ACC;
                n_axis   = !r_axis;
                if (!r_axis) begin
                    n_state = S_NUM;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = j_last ? S_STACC : S_PAIR;
                end
            end
            S_STACC: begin
                o_cmd.op = nbl_pkg::OP_ST_ACC;
                n_i      = r_i + 1'b1;
                n_axis   = 1'b0;
                n_state  = i_last ? S_KICK : S_LATCH;
            end
            S_KICK: begin
                o_cmd.op = nbl_pkg::OP_KICK;
                n_state  = S_DRIFT2;
            end
            S_DRIFT2: begin
                o_cmd.op = nbl_pkg::OP_DRIFT;
                n_axis   = !r_axis;
                n_state  = S_KICK;
                if (r_axis) begin
                    n_i = r_i + 1'b1;
                    if (i_last) begin
                        n_j     = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.idx  = r_j;
                o_cmd.rd   = r_rd;
                o_cmd.last = r_rd || j_last;
                if (slot_free) begin
                    o_cmd.op = nbl_pkg::OP_EMIT;
                    n_ov     = 1'b1;
                    n_j      = r_j + 1'b1;
                    if (r_rd || j_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
            r_rd    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_rd    <= n_rd;
            r_ov    <= n_ov;
        end
    end

endmodule

### sv/nbl_dp.sv
// ============================================================================
// N-body leapfrog datapath
// Body stores, drift and kick arithmetic, serial square root and divider,
// acceleration accumulators and the result register.
// ============================================================================
module nbl_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nbl_pkg::t_cmd            i_cmd,
    output nbl_pkg::t_sts            o_sts,
    input  logic                     i_cfg_we,
    input  logic [23:0]              i_cfg_step,
    input  logic [30:0]              i_ld_mass,
    input  logic signed [31:0]       i_ld_pos_x,
    input  logic signed [31:0]       i_ld_pos_y,
    input  logic signed [31:0]       i_ld_vel_x,
    input  logic signed [31:0]       i_ld_vel_y,
    output logic [1:0]               o_index,
    output logic signed [31:0]       o_pos_x,
    output logic signed [31:0]       o_pos_y,
    output logic signed [31:0]       o_vel_x,
    output logic signed [31:0]       o_vel_y,
    output logic                     o_error,
    output logic                     o_last
);

    localparam int NB = nbl_pkg::NUM_BODIES;
    localparam logic [39:0] TERM_MAX = 40'h80_0000_0000;

    // Body stores and per-body accelerations.
    logic [30:0]        r_mass [NB];
    logic signed [31:0] r_posx [NB];
    logic signed [31:0] r_posy [NB];
    logic signed [31:0] r_velx [NB];
    logic signed [31:0] r_vely [NB];
    logic signed [39:0] r_accx_st [NB];
    logic signed [39:0] r_accy_st [NB];

    logic [23:0]        r_h;
    logic               r_err;

    // Pair working registers.
    logic signed [31:0] r_pix, r_piy;
    logic signed [39:0] r_accx, r_accy;
    logic signed [32:0] r_dx, r_dy;
    logic [30:0]        r_mj;
    logic [65:0]        r_r2;
    logic [65:0]        r_sx;
    logic [33:0]        r_rem;
    logic [32:0]        r_root;
    logic [98:0]        r_den;
    logic [63:0]        r_num;
    logic               r_dneg;
    logic               r_big;
    logic [99:0]        r_drem;
    logic [39:0]        r_q;

    // Selected body fields.
    logic signed [31:0] sel_pos, sel_vel;
    logic signed [39:0] sel_acc;
    logic signed [32:0] sel_d;
    logic [32:0]        dx_mag, dy_mag, d_mag;

    // Drift arithmetic.
    logic [31:0]        dr_mag;
    logic [55:0]        dr_prod;
    logic [30:0]        dr_sh;
    logic signed [32:0] dr_delta;
    nbl_pkg::t_sat      dr_res;

    // Kick arithmetic.
    logic [39:0]        kk_mag;
    logic [63:0]        kk_prod;
    logic [39:0]        kk_sh;
    logic signed [40:0] kk_delta;
    nbl_pkg::t_sat      kk_res;

    // Square root step.
    logic [35:0]        sq_cand;
    logic [35:0]        sq_trial;
    logic               sq_take;

    // Divider step.
    logic [99:0]        dv_sh;
    logic               dv_take;

    // Accumulation.
    logic signed [39:0] ac_cur;
    logic [39:0]        ac_mag;
    logic               ac_clip;
    logic signed [40:0] ac_term;
    logic signed [41:0] ac_sum;
    logic signed [39:0] ac_new;
    logic               ac_ovf;

    assign o_sts.r2_zero = (r_r2 == '0);
    assign o_sts.err     = r_err;

    // Operand selection by axis and body.
    always_comb begin
        sel_pos = i_cmd.axis ? r_posy[i_cmd.idx] : r_posx[i_cmd.idx];
        sel_vel = i_cmd.axis ? r_vely[i_cmd.idx] : r_velx[i_cmd.idx];
        sel_acc = i_cmd.axis ? r_accy_st[i_cmd.idx] : r_accx_st[i_cmd.idx];
        sel_d   = i_cmd.axis ? r_dy : r_dx;
        dx_mag  = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        dy_mag  = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
        d_mag   = i_cmd.axis ? dy_mag : dx_mag;
    end

    // Half drift: pos += sign(v) * ((|v| * h) >> 25), saturated.
    always_comb begin
        dr_mag   = sel_vel[31] ? 32'(-sel_vel) : 32'(sel_vel);
        dr_prod  = 56'(dr_mag) * 56'(r_h);
        dr_sh    = dr_prod[55:25];
        dr_delta = sel_vel[31] ? -$signed({2'b00, dr_sh}) : $signed({2'b00, dr_sh});
        dr_res   = nbl_pkg::sat32(42'(sel_pos) + 42'(dr_delta));
    end

    // Kick: v += sign(a) * ((|a| * h) >> 24), saturated.
    always_comb begin
        kk_mag   = sel_acc[39] ? 40'(-sel_acc) : 40'(sel_acc);
        kk_prod  = 64'(kk_mag) * 64'(r_h);
        kk_sh    = kk_prod[63:24];
        kk_delta = sel_acc[39] ? -$signed({1'b0, kk_sh}) : $signed({1'b0, kk_sh});
        kk_res   = nbl_pkg::sat32(42'(sel_vel) + 42'(kk_delta));
    end

    // One bit of the restoring square root.
    always_comb begin
        sq_cand  = {r_rem, r_sx[65:64]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_take  = (sq_cand >= sq_trial);
    end

    // One quotient bit; the dividend below the initial remainder is all zero.
    always_comb begin
        dv_sh   = {r_drem[98:0], 1'b0};
        dv_take = (dv_sh >= {1'b0, r_den});
    end

    // Pair term clipping and accumulator add with clipping.
    always_comb begin
        ac_cur  = i_cmd.axis ? r_accy : r_accx;
        ac_clip = r_big || (r_q > TERM_MAX);
        ac_mag  = ac_clip ? TERM_MAX : r_q;
        ac_term = r_dneg ? -$signed({1'b0, ac_mag}) : $signed({1'b0, ac_mag});
        ac_sum  = 42'(ac_cur) + 42'(ac_term);
        ac_ovf  = 1'b0;
        ac_new  = ac_sum[39:0];
        if (ac_sum > 42'sh007FFFFFFFFF) begin
            ac_new = 40'sh7F_FFFF_FFFF;
            ac_ovf = 1'b1;
        end else if (ac_sum < -42'sh008000000000) begin
            ac_new = 40'sh80_0000_0000;
            ac_ovf = 1'b1;
        end
    end

    // Time step register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= nbl_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            r_h <= i_cfg_step;
        end
    end

    // Body stores, accelerations and error flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NB; k++) begin
                r_mass[k]    <= '0;
                r_posx[k]    <= '0;
                r_posy[k]    <= '0;
                r_velx[k]    <= '0;
                r_vely[k]    <= '0;
                r_accx_st[k] <= '0;
                r_accy_st[k] <= '0;
            end
            r_err <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                nbl_pkg::OP_LOAD: begin
                    r_mass[i_cmd.idx] <= i_ld_mass;
                    r_posx[i_cmd.idx] <= i_ld_pos_x;
                    r_posy[i_cmd.idx] <= i_ld_pos_y;
                    r_velx[i_cmd.idx] <= i_ld_vel_x;
                    r_vely[i_cmd.idx] <= i_ld_vel_y;
                end
                nbl_pkg::OP_CLR_ERR: begin
                    r_err <= 1'b0;
                end
                nbl_pkg::OP_DRIFT: begin
                    if (i_cmd.axis) begin
                        r_posy[i_cmd.idx] <= dr_res.val;
                    end else begin
                        r_posx[i_cmd.idx] <= dr_res.val;
                    end
                    r_err <= r_err | dr_res.ovf;
                end
                nbl_pkg::OP_KICK: begin
                    if (i_cmd.axis) begin
                        r_vely[i_cmd.idx] <= kk_res.val;
                    end else begin
                        r_velx[i_cmd.idx] <= kk_res.val;
                    end
                    r_err <= r_err | kk_res.ovf;
                end
                nbl_pkg::OP_COIN: begin
                    r_err <= 1'b1;
                end
                nbl_pkg::OP_ACC: begin
                    r_err <= r_err | ac_clip | ac_ovf;
                end
                nbl_pkg::OP_ST_ACC: begin
                    r_accx_st[i_cmd.idx] <= r_accx;
                    r_accy_st[i_cmd.idx] <= r_accy;
                end
                default: begin
                end
            endcase
        end
    end

    // Pair pipeline working registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            nbl_pkg::OP_LATCH: begin
                r_pix  <= r_posx[i_cmd.idx];
                r_piy  <= r_posy[i_cmd.idx];
                r_accx <= '0;
                r_accy <= '0;
            end
            nbl_pkg::OP_DIFF: begin
                r_dx <= 33'(r_posx[i_cmd.idx]) - 33'(r_pix);
                r_dy <= 33'(r_posy[i_cmd.idx]) - 33'(r_piy);
                r_mj <= r_mass[i_cmd.idx];
            end
            nbl_pkg::OP_SQX: begin
                r_r2 <= 66'(dx_mag) * 66'(dx_mag);
            end
            nbl_pkg::OP_SQY: begin
                r_r2 <= r_r2 + 66'(dy_mag) * 66'(dy_mag);
            end
            nbl_pkg::OP_SQRT_INIT: begin
                r_sx   <= r_r2;
                r_rem  <= '0;
                r_root <= '0;
            end
            nbl_pkg::OP_SQRT_STEP: begin
                r_sx <= {r_sx[63:0], 2'b00};
                if (sq_take) begin
                    r_rem  <= 34'(sq_cand - sq_trial);
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= sq_cand[33:0];
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
            nbl_pkg::OP_DEN_LO: begin
                r_den <= 99'(r_r2[32:0]) * 99'(r_root);
            end
            nbl_pkg::OP_DEN_HI: begin
                r_den <= r_den + {66'(r_r2[65:33]) * 66'(r_root), 33'b0};
            end
            nbl_pkg::OP_NUM: begin
                r_num  <= 64'(r_mj) * 64'(d_mag);
                r_dneg <= sel_d[32];
            end
            nbl_pkg::OP_DIV_INIT: begin
                r_big  <= ({27'b0, r_num, 8'b0} >= r_den);
                r_drem <= {28'b0, r_num, 8'b0};
                r_q    <= '0;
            end
            nbl_pkg::OP_DIV_STEP: begin
                if (dv_take) begin
                    r_drem <= dv_sh - {1'b0, r_den};
                end else begin
                    r_drem <= dv_sh;
                end
                r_q <= {r_q[38:0], dv_take};
            end
            nbl_pkg::OP_ACC: begin
                if (i_cmd.axis) begin
                    r_accy <= ac_new;
                end else begin
                    r_accx <= ac_new;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == nbl_pkg::OP_EMIT) begin
            o_index <= 2'(i_cmd.idx);
            o_pos_x <= r_posx[i_cmd.idx];
            o_pos_y <= r_posy[i_cmd.idx];
            o_vel_x <= r_velx[i_cmd.idx];
            o_vel_y <= r_vely[i_cmd.idx];
            o_error <= i_cmd.rd ? 1'b0 : r_err;
            o_last  <= i_cmd.last;
        end
    end

endmodule

### sv/nbody_leapfrog_step_core.sv
// ============================================================================
// N-body leapfrog step core
// Four-body 2-D gravity integrator in Q8.24 with load, read and step requests.
//
//   Channel  Dir  Carries
//   i_in     in   req_type, body_index, body_mass, load_pos_x/y, load_vel_x/y
//   o_out    out  out_index, out_pos_x/y, out_vel_x/y, error_flag, last_result
//   i_cfg    in   step_size (time step h, Q0.24)
//
// A load writes the body store when it is accepted; a read offers one result.
// A step does a half drift, then 12 body pairs, each through the bit-serial
// square root and the bit-serial divider (once per axis), then kick and drift
// per body and the four results.
// Reset is synchronous and active low; it clears all bodies and sets h to 5033.
// A stalled result holds the sequencer in its result stage; requests are taken
// only between requests, while an earlier result may still be waiting.
// ============================================================================
module nbody_leapfrog_step_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nbl_in_if.sink     i_in,
    nbl_out_if.source  o_out,
    nbl_cfg_if.sink    i_cfg
);

    nbl_pkg::t_cmd cmd;
    nbl_pkg::t_sts sts;

    // The time step register takes a write in any cycle.
    assign i_cfg.ready = 1'b1;

    // Request sequencer.
    nbl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_req_type   (i_in.req_type),
        .i_body_index (i_in.body_index),
        .o_in_ready   (i_in.ready),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // Arithmetic and storage.
    nbl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_step (i_cfg.step_size),
        .i_ld_mass  (i_in.body_mass),
        .i_ld_pos_x (i_in.load_pos_x),
        .i_ld_pos_y (i_in.load_pos_y),
        .i_ld_vel_x (i_in.load_vel_x),
        .i_ld_vel_y (i_in.load_vel_y),
        .o_index    (o_out.out_index),
        .o_pos_x    (o_out.out_pos_x),
        .o_pos_y    (o_out.out_pos_y),
        .o_vel_x    (o_out.out_vel_x),
        .o_vel_y    (o_out.out_vel_y),
        .o_error    (o_out.error_flag),
        .o_last     (o_out.last_result)
    );

endmodule

### sv/nbl_checker.sv
// ============================================================================
// N-body leapfrog port checker
// Concurrent checks on the top level's ports, attached by bind.
// ============================================================================
module nbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_req_type,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_index,
    input logic [31:0] i_out_pos_x,
    input logic        i_out_last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its x position and its index.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pos_x) && $stable(i_out_index))
        else $error("result payload changed while stalled");

    // An accepted step request closes the input until the step is done.
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_req_type == nbl_pkg::REQ_STEP |=> !i_in_ready)
        else $error("input open right after a step request");

    // A result not marked as last never carries the highest body index.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_index != 2'(nbl_pkg::NUM_BODIES - 1))
        else $error("non-final result carries the last body index");

endmodule

bind nbody_leapfrog_step_core nbl_checker u_nbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_req_type  (i_in.req_type),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.out_index),
    .i_out_pos_x (o_out.out_pos_x),
    .i_out_last  (o_out.last_result)
);
